// ----- hw/rtl/photometric_normal_estimator_core_defines.svh -----
// assertion macros for the photometric normal estimator
// the user scope must provide clk and rst
`ifndef PHOTOMETRIC_NORMAL_ESTIMATOR_CORE_DEFINES_SVH
`define PHOTOMETRIC_NORMAL_ESTIMATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PNE_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define PNE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define PNE_ASSERT(label, expr, msg)
`define PNE_ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/pne_pkg.sv -----
// ----------------------------------------------------------------------------
// pne_pkg
// types and fixed widths shared by the normal estimator modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pne_pkg;

  localparam int MAX_LIGHTS  = 4;
  localparam int INT_W       = 8;
  localparam int COEF_W      = 16;
  localparam int ROW_W       = COEF_W * MAX_LIGHTS;
  localparam int PROD_W      = 24;
  localparam int VEC_W       = 26;
  localparam int MAG_W       = 25;
  localparam int NRM_W       = 20;
  localparam int SH_W        = 5;
  localparam int SQ_W        = 2 * NRM_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int RAD_SHIFT   = 20;
  localparam int RAD_W       = SUM_W + RAD_SHIFT;
  localparam int ISQRT_STEPS = RAD_W / 2;
  localparam int ROOT_W      = 31;
  localparam int QN_SHIFT    = 24;
  localparam int QN_W        = NRM_W + QN_SHIFT + 1;
  localparam int QN_Q        = 16;
  localparam int OUT_W       = 16;
  localparam int UNIT_W      = 15;
  localparam int GN_W        = 24;
  localparam int GQ_W        = 23;
  localparam int GRAD_FRAC   = 8;
  localparam int REG_IDX_W   = 2;

  localparam logic [QN_Q-1:0]    UNIT_Q     = QN_Q'(16384);
  localparam logic [UNIT_W-1:0]  UNIT_MAG   = UNIT_W'(16384);
  localparam logic [GQ_W-1:0]    GRAD_POS   = GQ_W'(32767);
  localparam logic [GQ_W-1:0]    GRAD_NEG   = GQ_W'(32768);
  localparam logic signed [OUT_W-1:0] GRAD_HI = 16'sh7fff;
  localparam logic signed [OUT_W-1:0] GRAD_LO = 16'sh8000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW_X = 2'd0,
    REG_ROW_Y = 2'd1,
    REG_ROW_Z = 2'd2
  } reg_index_t;

  typedef logic [2:0][ROW_W-1:0] coef_rows_t;

  typedef struct packed {
    logic [INT_W-1:0] intensity_0;
    logic [INT_W-1:0] intensity_1;
    logic [INT_W-1:0] intensity_2;
    logic [INT_W-1:0] intensity_3;
    logic             frame_end;
  } pixel_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic signed [OUT_W-1:0] grad_p;
    logic signed [OUT_W-1:0] grad_q;
    logic                    grad_saturated;
    logic                    frame_end_out;
  } normal_t;

  typedef struct packed {
    logic                  frame_end;
    logic [2:0][VEC_W-1:0] v;
  } dot_out_t;

  typedef struct packed {
    logic                  frame_end;
    logic                  zero;
    logic [2:0]            neg;
    logic [2:0][NRM_W-1:0] mag;
  } norm_side_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pne_dot.sv -----
// ----------------------------------------------------------------------------
// pne_dot
// light matrix times intensity vector, products then row sums
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pne_dot #(
  parameter int NUM_LIGHTS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  pne_pkg::pixel_t     pixel,
  input  pne_pkg::coef_rows_t coefs,
  output logic                out_valid,
  output pne_pkg::dot_out_t   dout
);

  logic [pne_pkg::INT_W-1:0]         inten [pne_pkg::MAX_LIGHTS];
  logic signed [pne_pkg::PROD_W-1:0] prod [3][NUM_LIGHTS];
  logic                              prod_valid;
  logic                              prod_fe;
  logic [2:0][pne_pkg::VEC_W-1:0]    acc;

  always_comb begin
    inten[0] = pixel.intensity_0;
    inten[1] = pixel.intensity_1;
    inten[2] = pixel.intensity_2;
    inten[3] = pixel.intensity_3;
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (adv) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_fe <= pixel.frame_end;
      for (int r = 0; r < 3; r++) begin
        for (int l = 0; l < NUM_LIGHTS; l++) begin
          prod[r][l] <= pne_pkg::PROD_W'(
            $signed(coefs[r][pne_pkg::COEF_W*l +: pne_pkg::COEF_W]) *
            $signed({1'b0, inten[l]}));
        end
      end
    end
  end

  // stage 2: row sums
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = '0;
      for (int l = 0; l < NUM_LIGHTS; l++) begin
        acc[r] = pne_pkg::VEC_W'($signed(acc[r]) + pne_pkg::VEC_W'(prod[r][l]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout.frame_end <= prod_fe;
      dout.v         <= acc;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pne_norm.sv -----
// ----------------------------------------------------------------------------
// pne_norm
// magnitude, block scaling to a fixed exponent, and sum of squares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pne_norm (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  pne_pkg::dot_out_t          din,
  output logic                       out_valid,
  output logic [pne_pkg::SUM_W-1:0]  sum_sq,
  output pne_pkg::norm_side_t        side
);

  localparam int MAG_W = pne_pkg::MAG_W;
  localparam int NRM_W = pne_pkg::NRM_W;
  localparam int SH_W  = pne_pkg::SH_W;

  // stage 1: abs and max
  logic [2:0][MAG_W-1:0]          abs_c;
  logic [MAG_W-1:0]               max_c;
  logic                           s1_valid;
  logic                           s1_fe;
  logic [2:0]                     s1_neg;
  logic [2:0][MAG_W-1:0]          s1_abs;
  logic [MAG_W-1:0]               s1_max;

  // stage 2: shift amount
  logic [SH_W-1:0]                msb_c;
  logic                           s2_valid;
  logic                           s2_fe;
  logic                           s2_zero;
  logic [2:0]                     s2_neg;
  logic [2:0][MAG_W-1:0]          s2_abs;
  logic                           s2_right;
  logic [SH_W-1:0]                s2_shamt;

  // stage 3: scaled magnitudes
  logic [2:0][MAG_W-1:0]          scaled_c;
  logic                           s3_valid;
  pne_pkg::norm_side_t            s3_side;

  // stage 4: squares
  logic                           s4_valid;
  pne_pkg::norm_side_t            s4_side;
  logic [2:0][pne_pkg::SQ_W-1:0]  s4_sq;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      abs_c[r] = din.v[r][pne_pkg::VEC_W-1] ? MAG_W'(~din.v[r] + 1'b1) : MAG_W'(din.v[r]);
    end
    max_c = abs_c[0];
    if (abs_c[1] > max_c) max_c = abs_c[1];
    if (abs_c[2] > max_c) max_c = abs_c[2];
  end

  always_comb begin
    msb_c = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (s1_max[b]) msb_c = SH_W'(b);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      scaled_c[r] = s2_right ? (s2_abs[r] >> s2_shamt) : (s2_abs[r] << s2_shamt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_fe  <= din.frame_end;
      s1_abs <= abs_c;
      s1_max <= max_c;
      for (int r = 0; r < 3; r++) begin
        s1_neg[r] <= din.v[r][pne_pkg::VEC_W-1];
      end

      // right shift when the max reaches 2^20, else left up to bit 19
      s2_fe    <= s1_fe;
      s2_neg   <= s1_neg;
      s2_abs   <= s1_abs;
      s2_zero  <= (s1_max == '0);
      s2_right <= (msb_c > SH_W'(NRM_W - 1));
      s2_shamt <= (msb_c > SH_W'(NRM_W - 1)) ? (msb_c - SH_W'(NRM_W - 1))
                                             : (SH_W'(NRM_W - 1) - msb_c);

      s3_side.frame_end <= s2_fe;
      s3_side.zero      <= s2_zero;
      s3_side.neg       <= s2_neg;
      for (int r = 0; r < 3; r++) begin
        s3_side.mag[r] <= scaled_c[r][NRM_W-1:0];
      end

      s4_side <= s3_side;
      for (int r = 0; r < 3; r++) begin
        s4_sq[r] <= s3_side.mag[r] * s3_side.mag[r];
      end

      side   <= s4_side;
      sum_sq <= pne_pkg::SUM_W'(s4_sq[0]) + pne_pkg::SUM_W'(s4_sq[1])
              + pne_pkg::SUM_W'(s4_sq[2]);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pne_isqrt.sv -----
// ----------------------------------------------------------------------------
// pne_isqrt
// integer square root of sum_sq * 2^20, one result bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pne_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [pne_pkg::SUM_W-1:0]  sum_sq,
  input  pne_pkg::norm_side_t        side_in,
  output logic                       out_valid,
  output logic [pne_pkg::ROOT_W-1:0] root,
  output pne_pkg::norm_side_t        side_out
);

  localparam int RAD_W = pne_pkg::RAD_W;
  localparam int STEPS = pne_pkg::ISQRT_STEPS;

  logic                vld  [STEPS];
  logic [RAD_W-1:0]    rem  [STEPS];
  logic [RAD_W-1:0]    res  [STEPS];
  pne_pkg::norm_side_t sd   [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [RAD_W-1:0] STEP_BIT = RAD_W'(1) << (RAD_W - 2 - 2 * i);
    logic                src_v;
    logic [RAD_W-1:0]    src_rem;
    logic [RAD_W-1:0]    src_res;
    pne_pkg::norm_side_t src_sd;
    logic [RAD_W:0]      trial;
    logic                take;

    if (i == 0) begin : g_first
      assign src_v   = in_valid;
      assign src_rem = {sum_sq, pne_pkg::RAD_SHIFT'(0)};
      assign src_res = '0;
      assign src_sd  = side_in;
    end else begin : g_next
      assign src_v   = vld[i-1];
      assign src_rem = rem[i-1];
      assign src_res = res[i-1];
      assign src_sd  = sd[i-1];
    end

    assign trial = {1'b0, src_res} + {1'b0, STEP_BIT};
    assign take  = {1'b0, src_rem} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd[i]  <= src_sd;
        rem[i] <= take ? RAD_W'({1'b0, src_rem} - trial) : src_rem;
        res[i] <= take ? ((src_res >> 1) + STEP_BIT) : (src_res >> 1);
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign root      = res[STEPS-1][pne_pkg::ROOT_W-1:0];
  assign side_out  = sd[STEPS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/pne_div.sv -----
// ----------------------------------------------------------------------------
// pne_div
// restoring divider, one quotient bit per stage, side data rides along
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pne_div #(
  parameter int NUM_W  = 45,
  parameter int DEN_W  = 31,
  parameter int QUO_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [QUO_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  // the upper numerator bits must already be below den
  logic              vld   [QUO_W];
  logic [DEN_W-1:0]  rem   [QUO_W];
  logic [DEN_W-1:0]  dv    [QUO_W];
  logic [QUO_W-1:0]  low   [QUO_W];
  logic [QUO_W-1:0]  qacc  [QUO_W];
  logic [SIDE_W-1:0] sd    [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    logic              src_v;
    logic [DEN_W-1:0]  src_rem;
    logic [DEN_W-1:0]  src_den;
    logic [QUO_W-1:0]  src_low;
    logic [QUO_W-1:0]  src_quo;
    logic [SIDE_W-1:0] src_sd;
    logic [DEN_W:0]    trial;
    logic              take;

    if (i == 0) begin : g_first
      assign src_v   = in_valid;
      assign src_rem = DEN_W'(num[NUM_W-1:QUO_W]);
      assign src_den = den;
      assign src_low = num[QUO_W-1:0];
      assign src_quo = '0;
      assign src_sd  = side_in;
    end else begin : g_next
      assign src_v   = vld[i-1];
      assign src_rem = rem[i-1];
      assign src_den = dv[i-1];
      assign src_low = low[i-1];
      assign src_quo = qacc[i-1];
      assign src_sd  = sd[i-1];
    end

    assign trial = {src_rem, src_low[QUO_W-1]};
    assign take  = trial >= {1'b0, src_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i]  <= take ? DEN_W'(trial - {1'b0, src_den}) : trial[DEN_W-1:0];
        dv[i]   <= src_den;
        low[i]  <= src_low << 1;
        qacc[i] <= (src_quo << 1) | QUO_W'(take);
        sd[i]   <= src_sd;
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign quo       = qacc[QUO_W-1];
  assign side_out  = sd[QUO_W-1];

endmodule

`default_nettype wire

// ----- hw/rtl/photometric_normal_estimator_core.sv -----
// ----------------------------------------------------------------------------
// photometric_normal_estimator_core: per-pixel unit normal and gradients
// pixel transfer to result is fully pipelined; one pixel per cycle sustained
// rate is set by the fully pipelined sqrt and dividers; a held result stalls all
// reset (rst, sync, high) clears the light matrix rows and all valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "photometric_normal_estimator_core_defines.svh"

module photometric_normal_estimator_core #(
  parameter int NUM_LIGHTS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  // pixel channel
  input  logic                           pixel_valid,
  output logic                           pixel_stall,
  input  pne_pkg::pixel_t                pixel,
  // result channel
  output logic                           normal_valid,
  input  logic                           normal_stall,
  output pne_pkg::normal_t               normal,
  // register writes
  input  logic                           cfg_we,
  input  logic [pne_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [pne_pkg::ROW_W-1:0]      cfg_data
);

  localparam int QN_W   = pne_pkg::QN_W;
  localparam int QN_Q   = pne_pkg::QN_Q;
  localparam int ROOT_W = pne_pkg::ROOT_W;
  localparam int OUT_W  = pne_pkg::OUT_W;
  localparam int UNIT_W = pne_pkg::UNIT_W;
  localparam int GN_W   = pne_pkg::GN_W;
  localparam int GQ_W   = pne_pkg::GQ_W;
  localparam int GS_W   = 2 + 3 * OUT_W;

  // global advance: the whole pipe moves unless the output register is held
  logic adv;

  pne_pkg::coef_rows_t coefs;

  // dot product and normalization front end
  logic                       dot_valid;
  pne_pkg::dot_out_t          dot_out;
  logic                       nrm_valid;
  logic [pne_pkg::SUM_W-1:0]  nrm_sum;
  pne_pkg::norm_side_t        nrm_side;
  logic                       sq_valid;
  logic [ROOT_W-1:0]          sq_root;
  pne_pkg::norm_side_t        sq_side;

  // numerator build stage
  logic                       pd_valid;
  logic [2:0][QN_W-1:0]       pd_num;
  logic [ROOT_W-1:0]          pd_root;
  logic                       pd_fe;
  logic                       pd_zero;
  logic [2:0]                 pd_neg;

  // normal dividers
  logic                       dx_valid;
  logic [2:0][QN_Q-1:0]       dq;
  logic [2:0]                 dx_side;
  logic                       dy_neg;
  logic                       dz_neg;

  // finished normal
  logic [2:0][QN_Q-1:0]       cap_c;
  logic [2:0][OUT_W-1:0]      nrm_c;
  logic                       f_valid;
  logic signed [OUT_W-1:0]    f_nx;
  logic signed [OUT_W-1:0]    f_ny;
  logic signed [OUT_W-1:0]    f_nz;
  logic                       f_fe;

  // gradient dividers
  logic [UNIT_W-1:0]          abs_x;
  logic [UNIT_W-1:0]          abs_y;
  logic [UNIT_W-1:0]          abs_z;
  logic [GN_W-1:0]            gnum_p;
  logic [GN_W-1:0]            gnum_q;
  logic                       gp_valid;
  logic [GQ_W-1:0]            gp_mag;
  logic [GQ_W-1:0]            gq_mag;
  logic [GS_W-1:0]            gp_side;
  logic                       gq_neg;
  logic                       gp_neg;
  logic                       gp_fe;
  logic signed [OUT_W-1:0]    gp_nx;
  logic signed [OUT_W-1:0]    gp_ny;
  logic signed [OUT_W-1:0]    gp_nz;

  // output saturation
  logic signed [OUT_W-1:0]    p_c;
  logic signed [OUT_W-1:0]    q_c;
  logic                       p_sat;
  logic                       q_sat;

  assign pixel_stall = normal_valid & normal_stall;
  assign adv         = ~pixel_stall;

  // ---------------------------------------------------------------------------
  // light matrix rows, one 64-bit register per row
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pne_pkg::REG_ROW_X: coefs[0] <= cfg_data;
        pne_pkg::REG_ROW_Y: coefs[1] <= cfg_data;
        pne_pkg::REG_ROW_Z: coefs[2] <= cfg_data;
        default: ;  // writes past the last row are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // matrix product (2 stages), scaling and sum of squares (5 stages)
  // ---------------------------------------------------------------------------
  pne_dot #(
    .NUM_LIGHTS (NUM_LIGHTS)
  ) u_dot (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (pixel_valid),
    .pixel     (pixel),
    .coefs     (coefs),
    .out_valid (dot_valid),
    .dout      (dot_out)
  );

  pne_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (dot_valid),
    .din       (dot_out),
    .out_valid (nrm_valid),
    .sum_sq    (nrm_sum),
    .side      (nrm_side)
  );

  // length of the scaled vector, 31 stages
  pne_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (nrm_valid),
    .sum_sq    (nrm_sum),
    .side_in   (nrm_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  // ---------------------------------------------------------------------------
  // numerator a * 2^24 + r/2 for round-to-nearest division by r
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pd_valid <= 1'b0;
    end else if (adv) begin
      pd_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        pd_num[r] <= QN_W'({sq_side.mag[r], pne_pkg::QN_SHIFT'(0)}) + QN_W'(sq_root >> 1);
      end
      pd_root <= sq_root;
      pd_fe   <= sq_side.frame_end;
      pd_zero <= sq_side.zero;
      pd_neg  <= sq_side.neg;
    end
  end

  // ---------------------------------------------------------------------------
  // component dividers, 16 stages; a zero vector gives r = 0 and is
  // overridden below
  // ---------------------------------------------------------------------------
  pne_div #(
    .NUM_W  (QN_W),
    .DEN_W  (ROOT_W),
    .QUO_W  (QN_Q),
    .SIDE_W (3)
  ) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (pd_valid),
    .num       (pd_num[0]),
    .den       (pd_root),
    .side_in   ({pd_fe, pd_zero, pd_neg[0]}),
    .out_valid (dx_valid),
    .quo       (dq[0]),
    .side_out  (dx_side)
  );

  pne_div #(
    .NUM_W  (QN_W),
    .DEN_W  (ROOT_W),
    .QUO_W  (QN_Q),
    .SIDE_W (1)
  ) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (pd_valid),
    .num       (pd_num[1]),
    .den       (pd_root),
    .side_in   (pd_neg[1]),
    .out_valid (),
    .quo       (dq[1]),
    .side_out  (dy_neg)
  );

  pne_div #(
    .NUM_W  (QN_W),
    .DEN_W  (ROOT_W),
    .QUO_W  (QN_Q),
    .SIDE_W (1)
  ) u_div_z (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (pd_valid),
    .num       (pd_num[2]),
    .den       (pd_root),
    .side_in   (pd_neg[2]),
    .out_valid (),
    .quo       (dq[2]),
    .side_out  (dz_neg)
  );

  // ---------------------------------------------------------------------------
  // cap at 1.0, apply sign, zero vector to 0, zero nz to 1.0
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [2:0] neg;
    neg = {dz_neg, dy_neg, dx_side[0]};
    for (int r = 0; r < 3; r++) begin
      cap_c[r] = (dq[r] > pne_pkg::UNIT_Q) ? pne_pkg::UNIT_Q : dq[r];
      nrm_c[r] = neg[r] ? OUT_W'(~cap_c[r] + 1'b1) : OUT_W'(cap_c[r]);
      if (dx_side[1]) nrm_c[r] = '0;
    end
    if (nrm_c[2] == '0) nrm_c[2] = OUT_W'(pne_pkg::UNIT_Q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= dx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_nx <= $signed(nrm_c[0]);
      f_ny <= $signed(nrm_c[1]);
      f_nz <= $signed(nrm_c[2]);
      f_fe <= dx_side[2];
    end
  end

  // ---------------------------------------------------------------------------
  // gradients |n| * 256 + |nz|/2 over |nz|, 23 stages, sign kept aside
  // ---------------------------------------------------------------------------
  assign abs_x  = f_nx[OUT_W-1] ? UNIT_W'(~f_nx + 1'b1) : UNIT_W'(f_nx);
  assign abs_y  = f_ny[OUT_W-1] ? UNIT_W'(~f_ny + 1'b1) : UNIT_W'(f_ny);
  assign abs_z  = f_nz[OUT_W-1] ? UNIT_W'(~f_nz + 1'b1) : UNIT_W'(f_nz);
  assign gnum_p = GN_W'({abs_x, pne_pkg::GRAD_FRAC'(0)}) + GN_W'(abs_z >> 1);
  assign gnum_q = GN_W'({abs_y, pne_pkg::GRAD_FRAC'(0)}) + GN_W'(abs_z >> 1);

  pne_div #(
    .NUM_W  (GN_W),
    .DEN_W  (UNIT_W),
    .QUO_W  (GQ_W),
    .SIDE_W (GS_W)
  ) u_grad_p (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .num       (gnum_p),
    .den       (abs_z),
    .side_in   ({f_fe, f_nx[OUT_W-1] ^ f_nz[OUT_W-1], f_nx, f_ny, f_nz}),
    .out_valid (gp_valid),
    .quo       (gp_mag),
    .side_out  (gp_side)
  );

  pne_div #(
    .NUM_W  (GN_W),
    .DEN_W  (UNIT_W),
    .QUO_W  (GQ_W),
    .SIDE_W (1)
  ) u_grad_q (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .num       (gnum_q),
    .den       (abs_z),
    .side_in   (f_ny[OUT_W-1] ^ f_nz[OUT_W-1]),
    .out_valid (),
    .quo       (gq_mag),
    .side_out  (gq_neg)
  );

  assign {gp_fe, gp_neg, gp_nx, gp_ny, gp_nz} = gp_side;

  // saturate to signed q8.8
  always_comb begin
    p_sat = 1'b0;
    q_sat = 1'b0;
    if (gp_neg) begin
      if (gp_mag > pne_pkg::GRAD_NEG) begin
        p_c   = pne_pkg::GRAD_LO;
        p_sat = 1'b1;
      end else begin
        p_c = $signed(OUT_W'(~gp_mag + 1'b1));
      end
    end else begin
      if (gp_mag > pne_pkg::GRAD_POS) begin
        p_c   = pne_pkg::GRAD_HI;
        p_sat = 1'b1;
      end else begin
        p_c = $signed(OUT_W'(gp_mag));
      end
    end
    if (gq_neg) begin
      if (gq_mag > pne_pkg::GRAD_NEG) begin
        q_c   = pne_pkg::GRAD_LO;
        q_sat = 1'b1;
      end else begin
        q_c = $signed(OUT_W'(~gq_mag + 1'b1));
      end
    end else begin
      if (gq_mag > pne_pkg::GRAD_POS) begin
        q_c   = pne_pkg::GRAD_HI;
        q_sat = 1'b1;
      end else begin
        q_c = $signed(OUT_W'(gq_mag));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register; holds while the result transfer is stalled
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_valid <= 1'b0;
    end else if (adv) begin
      normal_valid <= gp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      normal.normal_x       <= gp_nx;
      normal.normal_y       <= gp_ny;
      normal.normal_z       <= gp_nz;
      normal.grad_p         <= p_c;
      normal.grad_q         <= q_c;
      normal.grad_saturated <= p_sat | q_sat;
      normal.frame_end_out  <= gp_fe;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `PNE_ASSERT_IMPLY(a_nz_nonzero, normal_valid, normal.normal_z != 16'sd0, "normal_z is zero")
  `PNE_ASSERT_IMPLY(a_sat_at_limit, normal_valid && normal.grad_saturated, normal.grad_p == pne_pkg::GRAD_HI || normal.grad_p == pne_pkg::GRAD_LO || normal.grad_q == pne_pkg::GRAD_HI || normal.grad_q == pne_pkg::GRAD_LO, "saturation flag without clipped gradient")
  `PNE_ASSERT_IMPLY(a_unit_range, normal_valid, normal.normal_x <= 16'sd16384 && normal.normal_x >= -16'sd16384 && normal.normal_y <= 16'sd16384 && normal.normal_y >= -16'sd16384, "normal component beyond unit")

endmodule

`default_nettype wire
